[rtl/det_pkg.sv]
// Shared types, constants and codes for the dispute escalation table.
package det_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int NODE_COUNT  = 16;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [8:0] NODE_LIMIT = 9'(NODE_COUNT);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // operation codes
    localparam logic [1:0] OP_OPEN     = 2'd0;
    localparam logic [1:0] OP_ESCALATE = 2'd1;
    localparam logic [1:0] OP_RESOLVE  = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_RULE  = 2'd2;

    // slot state codes
    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_ACTIVE   = 2'd1;
    localparam logic [1:0] SLOT_RESOLVED = 2'd2;
    localparam logic [1:0] SLOT_CUT      = 2'd3;

    // escalation levels
    localparam logic [1:0] LVL_PRIVATE  = 2'd0;
    localparam logic [1:0] LVL_WITNESS  = 2'd1;
    localparam logic [1:0] LVL_ASSEMBLY = 2'd2;
    localparam logic [1:0] LVL_CUT      = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] dispute_id;
        logic [7:0]  accuser_node;
        logic [7:0]  accused_node;
        logic [47:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  level;
        logic [1:0]  entry_state;
        logic [7:0]  party_accuser;
        logic [7:0]  party_accused;
        logic [47:0] opened_ms;
        logic [47:0] escalated_ms;
        logic        broadcast_request;
    } rsp_t;

    // queued item with its front-end classification
    typedef struct packed {
        cmd_t cmd;
        logic range_err;
        logic same_node;
    } qent_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_PICK,
        BK_WRITE
    } back_state_t;

endpackage

[rtl/dispute_escalation_table_unit.sv]
// An item passes through the queue and the match, pick and write steps before done.
// The back-end sequencer (match, pick, write) takes the next item only after a write.
// A 2-item queue sits between front and back; busy rises only while that queue is full.
// done pulses for one cycle per item and the receiver cannot stall it.
// Reset marks every table slot empty at once; no clearing pass runs after reset.
// Top level of the dispute escalation table.
module dispute_escalation_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  det_pkg::cmd_t cmd,
    output logic          done,
    output det_pkg::rsp_t result
);
    import det_pkg::*;

    // queue handoff between the front end and the back end
    logic  q_valid;
    logic  q_pop;
    qent_t q_entry;

    // Front: take the item when the queue has room, flag node range and
    // equal-node faults, and hold it in the queue.
    det_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    // Back: drain one item at a time, compare its id against every slot,
    // choose the slot and status, then write back and register the result.
    det_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

[rtl/det_front.sv]
// Front end: accepts items, classifies node ids and queues them for the back end.
module det_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  det_pkg::cmd_t  cmd,
    output logic           q_valid,
    output det_pkg::qent_t q_entry,
    input  logic           q_pop
);
    import det_pkg::*;

    qent_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    qent_t              in_entry;

    assign busy    = (count_reg == QCNT_W'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (count_reg != '0);
    assign q_entry = q_mem[rd_ptr_reg];

    always_comb
    begin
        in_entry.cmd       = cmd;
        in_entry.range_err = ({1'b0, cmd.accuser_node} >= NODE_LIMIT)
                          || ({1'b0, cmd.accused_node} >= NODE_LIMIT);
        in_entry.same_node = (cmd.accuser_node == cmd.accused_node);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("queue popped while empty");
`endif

endmodule

[rtl/det_back.sv]
// Back end: table lookup, slot choice, update and result register.
module det_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  det_pkg::qent_t q_entry,
    output logic           q_pop,
    output logic           done,
    output det_pkg::rsp_t  result
);
    import det_pkg::*;

    back_state_t        state_reg, state_next;
    qent_t              cur_reg;
    logic [TABLE_SLOTS-1:0] match_reg, empty_reg, resolved_reg;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [1:0]         status_reg, status_next;
    rsp_t               rsp_reg, rsp_next;
    logic               done_reg;

    logic [1:0]         slot_state_reg     [TABLE_SLOTS];
    logic [1:0]         slot_level_reg     [TABLE_SLOTS];
    logic [31:0]        slot_id_reg        [TABLE_SLOTS];
    logic [7:0]         slot_accuser_reg   [TABLE_SLOTS];
    logic [7:0]         slot_accused_reg   [TABLE_SLOTS];
    logic [47:0]        slot_opened_reg    [TABLE_SLOTS];
    logic [47:0]        slot_escalated_reg [TABLE_SLOTS];

    logic               take_cmd, do_scan, do_pick, do_write, wr_en;
    logic               hit, any_empty, any_res;
    logic [SLOT_W-1:0]  hit_idx, empty_idx, res_idx;
    logic [1:0]         hit_state, hit_level;
    logic [1:0]         cur_state, cur_level;
    logic [1:0]         new_state, new_level;
    logic [7:0]         new_accuser, new_accused;
    logic [31:0]        new_id;
    logic [47:0]        new_opened, new_escalated;
    logic               bcast;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:  state_next = q_valid ? BK_MATCH : BK_IDLE;
            BK_MATCH: state_next = BK_PICK;
            BK_PICK:  state_next = BK_WRITE;
            BK_WRITE: state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        take_cmd = 1'b0;
        do_scan  = 1'b0;
        do_pick  = 1'b0;
        do_write = 1'b0;
        case (state_reg)
            BK_IDLE:  take_cmd = q_valid;
            BK_MATCH: do_scan  = 1'b1;
            BK_PICK:  do_pick  = 1'b1;
            BK_WRITE: do_write = 1'b1;
            default:  take_cmd = 1'b0;
        endcase
    end

    assign q_pop  = take_cmd;
    assign done   = done_reg;
    assign result = rsp_reg;

    // first match, first empty, first resolved: lowest index wins
    always_comb
    begin
        hit       = 1'b0;
        hit_idx   = '0;
        any_empty = 1'b0;
        empty_idx = '0;
        any_res   = 1'b0;
        res_idx   = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (empty_reg[i])
            begin
                any_empty = 1'b1;
                empty_idx = SLOT_W'(i);
            end
            if (resolved_reg[i])
            begin
                any_res = 1'b1;
                res_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_state = slot_state_reg[hit_idx];
    assign hit_level = slot_level_reg[hit_idx];

    // decide status and target slot
    always_comb
    begin
        status_next = STATUS_OK;
        idx_next    = hit_idx;
        case (cur_reg.cmd.op)
            OP_OPEN:
            begin
                if (cur_reg.range_err)
                    status_next = STATUS_RANGE;
                else if (cur_reg.same_node)
                    status_next = STATUS_RULE;
                else if (hit)
                begin
                    if (hit_state != SLOT_RESOLVED)
                        status_next = STATUS_RULE;
                end
                else if (any_empty)
                    idx_next = empty_idx;
                else if (any_res)
                    idx_next = res_idx;
                else
                    status_next = STATUS_RULE;
            end
            OP_ESCALATE:
            begin
                if (!hit)
                    status_next = STATUS_RULE;
                else if (hit_state != SLOT_ACTIVE || hit_level == LVL_CUT)
                    status_next = STATUS_RULE;
            end
            OP_RESOLVE:
            begin
                if (!hit)
                    status_next = STATUS_RULE;
                else if (hit_state == SLOT_CUT)
                    status_next = STATUS_RULE;
            end
            default:
            begin
                if (!hit)
                    status_next = STATUS_RULE;
            end
        endcase
    end

    // apply the update to the chosen slot
    assign cur_state = slot_state_reg[idx_reg];
    assign cur_level = slot_level_reg[idx_reg];

    always_comb
    begin
        new_state     = cur_state;
        new_level     = cur_level;
        new_id        = slot_id_reg[idx_reg];
        new_accuser   = slot_accuser_reg[idx_reg];
        new_accused   = slot_accused_reg[idx_reg];
        new_opened    = slot_opened_reg[idx_reg];
        new_escalated = slot_escalated_reg[idx_reg];
        bcast         = 1'b0;
        case (cur_reg.cmd.op)
            OP_OPEN:
            begin
                new_state     = SLOT_ACTIVE;
                new_level     = LVL_PRIVATE;
                new_id        = cur_reg.cmd.dispute_id;
                new_accuser   = cur_reg.cmd.accuser_node;
                new_accused   = cur_reg.cmd.accused_node;
                new_opened    = cur_reg.cmd.now_ms;
                new_escalated = cur_reg.cmd.now_ms;
            end
            OP_ESCALATE:
            begin
                new_level     = cur_level + 1'b1;
                new_escalated = cur_reg.cmd.now_ms;
                bcast         = (cur_level == LVL_WITNESS);
                if (cur_level == LVL_ASSEMBLY)
                    new_state = SLOT_CUT;
            end
            OP_RESOLVE:
            begin
                new_state = SLOT_RESOLVED;
            end
            default:
            begin
                new_state = cur_state;
            end
        endcase
    end

    assign wr_en = do_write && (status_reg == STATUS_OK);

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = status_reg;
        if (status_reg == STATUS_OK)
        begin
            rsp_next.level             = new_level;
            rsp_next.entry_state       = new_state - 2'd1;
            rsp_next.party_accuser     = new_accuser;
            rsp_next.party_accused     = new_accused;
            rsp_next.opened_ms         = new_opened;
            rsp_next.escalated_ms      = new_escalated;
            rsp_next.broadcast_request = bcast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_state_reg[i] <= SLOT_EMPTY;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= do_write;
            if (wr_en)
            begin
                slot_state_reg[idx_reg] <= new_state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_cmd)
        begin
            cur_reg <= q_entry;
        end
        if (do_scan)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                match_reg[i]    <= (slot_state_reg[i] != SLOT_EMPTY)
                                && (slot_id_reg[i] == cur_reg.cmd.dispute_id);
                empty_reg[i]    <= (slot_state_reg[i] == SLOT_EMPTY);
                resolved_reg[i] <= (slot_state_reg[i] == SLOT_RESOLVED);
            end
        end
        if (do_pick)
        begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
        end
        if (do_write)
        begin
            rsp_reg <= rsp_next;
        end
        if (wr_en)
        begin
            slot_level_reg[idx_reg]     <= new_level;
            slot_id_reg[idx_reg]        <= new_id;
            slot_accuser_reg[idx_reg]   <= new_accuser;
            slot_accused_reg[idx_reg]   <= new_accused;
            slot_opened_reg[idx_reg]    <= new_opened;
            slot_escalated_reg[idx_reg] <= new_escalated;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == BK_WRITE))
        else $error("result strobe without a write step");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status != STATUS_OK) |->
            (rsp_reg.level == 2'd0 && rsp_reg.entry_state == 2'd0
             && rsp_reg.opened_ms == '0 && rsp_reg.broadcast_request == 1'b0))
        else $error("error result carries entry data");

    a_bcast_level: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.broadcast_request) |-> (rsp_reg.level == LVL_ASSEMBLY))
        else $error("broadcast request without assembly level");

    a_open_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_WRITE && status_reg == STATUS_OK && cur_reg.cmd.op == OP_OPEN)
            |=> (slot_state_reg[$past(idx_reg)] == SLOT_ACTIVE))
        else $error("opened slot not active");
`endif

endmodule

[dv/dispute_ledger_pkg.sv]
// Predictor and result checker for the dispute escalation table testbench.
package dispute_ledger_pkg;

    import det_pkg::*;

    class dispute_ledger;

        logic [1:0]  slot_state     [TABLE_SLOTS];
        logic [1:0]  slot_level     [TABLE_SLOTS];
        logic [31:0] slot_id        [TABLE_SLOTS];
        logic [7:0]  slot_accuser   [TABLE_SLOTS];
        logic [7:0]  slot_accused   [TABLE_SLOTS];
        logic [47:0] slot_opened    [TABLE_SLOTS];
        logic [47:0] slot_escalated [TABLE_SLOTS];

        rsp_t        pending_results[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                slot_state[i]     = SLOT_EMPTY;
                slot_level[i]     = LVL_PRIVATE;
                slot_id[i]        = '0;
                slot_accuser[i]   = '0;
                slot_accused[i]   = '0;
                slot_opened[i]    = '0;
                slot_escalated[i] = '0;
            end
        endfunction

        // First occupied slot holding this id, or -1.
        function int find_dispute(logic [31:0] id);
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_state[i] != SLOT_EMPTY && slot_id[i] == id)
                    return i;
            return -1;
        endfunction

        // First empty slot, else first resolved slot, else -1.
        function int find_free_slot();
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_state[i] == SLOT_EMPTY)
                    return i;
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_state[i] == SLOT_RESOLVED)
                    return i;
            return -1;
        endfunction

        function rsp_t entry_view(int s, logic bcast);
            rsp_t r;
            r                   = '0;
            r.status            = STATUS_OK;
            r.level             = slot_level[s];
            r.entry_state       = slot_state[s] - 2'd1;
            r.party_accuser     = slot_accuser[s];
            r.party_accused     = slot_accused[s];
            r.opened_ms         = slot_opened[s];
            r.escalated_ms      = slot_escalated[s];
            r.broadcast_request = bcast;
            return r;
        endfunction

        // Apply one accepted item to the table and queue its expected result.
        function void note_item(cmd_t c);
            rsp_t r;
            int   s;
            logic bcast;
            r     = '0;
            bcast = 1'b0;
            s     = find_dispute(c.dispute_id);
            case (c.op)
                OP_OPEN:
                begin
                    if (c.accuser_node >= NODE_COUNT || c.accused_node >= NODE_COUNT)
                        r.status = STATUS_RANGE;
                    else if (c.accuser_node == c.accused_node)
                        r.status = STATUS_RULE;
                    else if (s >= 0 && slot_state[s] != SLOT_RESOLVED)
                        r.status = STATUS_RULE;
                    else
                    begin
                        if (s < 0)
                            s = find_free_slot();
                        if (s < 0)
                            r.status = STATUS_RULE;
                        else
                        begin
                            slot_id[s]        = c.dispute_id;
                            slot_accuser[s]   = c.accuser_node;
                            slot_accused[s]   = c.accused_node;
                            slot_level[s]     = LVL_PRIVATE;
                            slot_state[s]     = SLOT_ACTIVE;
                            slot_opened[s]    = c.now_ms;
                            slot_escalated[s] = c.now_ms;
                            r = entry_view(s, 1'b0);
                        end
                    end
                end
                OP_ESCALATE:
                begin
                    if (s < 0 || slot_state[s] != SLOT_ACTIVE || slot_level[s] == LVL_CUT)
                        r.status = STATUS_RULE;
                    else
                    begin
                        case (slot_level[s])
                            LVL_PRIVATE:  slot_level[s] = LVL_WITNESS;
                            LVL_WITNESS:
                            begin
                                slot_level[s] = LVL_ASSEMBLY;
                                bcast         = 1'b1;
                            end
                            default:
                            begin
                                slot_level[s] = LVL_CUT;
                                slot_state[s] = SLOT_CUT;
                            end
                        endcase
                        slot_escalated[s] = c.now_ms;
                        r = entry_view(s, bcast);
                    end
                end
                OP_RESOLVE:
                begin
                    if (s < 0 || slot_state[s] == SLOT_CUT)
                        r.status = STATUS_RULE;
                    else
                    begin
                        slot_state[s] = SLOT_RESOLVED;
                        r = entry_view(s, 1'b0);
                    end
                end
                default:
                begin
                    if (s < 0)
                        r.status = STATUS_RULE;
                    else
                        r = entry_view(s, 1'b0);
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: 0x%0h", got);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("level", want.level, got.level);
            compare_field("entry_state", want.entry_state, got.entry_state);
            compare_field("party_accuser", want.party_accuser, got.party_accuser);
            compare_field("party_accused", want.party_accused, got.party_accused);
            compare_field("opened_ms", want.opened_ms, got.opened_ms);
            compare_field("escalated_ms", want.escalated_ms, got.escalated_ms);
            compare_field("broadcast_request", want.broadcast_request,
                          got.broadcast_request);
        endfunction

    endclass

endpackage

[dv/testbench.sv]
// Top-level testbench: drives table commands and checks every result against the predictor.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import det_pkg::*;
    import dispute_ledger_pkg::*;

    logic  clk   = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    cmd_t  cmd   = '0;
    logic  done;
    rsp_t  result;

    dispute_ledger ledger;

    // Random stimulus state: a pool of live ids and a running millisecond clock.
    logic [31:0] id_pool[$];
    logic [47:0] clock_ms = '0;
    bit          steady_phase = 1'b0;

    dispute_escalation_table_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Check every result in the cycle its strobe is high; the receiver never stalls.
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(result);
    end

    // Hard stop in case the block hangs. The slowest correct run is well under
    // a millisecond (about 600 items, each at most its longest gap plus work).
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Mostly back-to-back or short gaps, occasionally a long one.
    // A steady phase never idles, so the queue fills and busy gets exercised.
    function int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (steady_phase || k < 55)
            return 0;
        else if (k < 85)
            return $urandom_range(1, 3);
        else if (k < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Present one item at the falling edge and hold it until a rising edge
    // sees start with busy low; note it with the predictor at that edge.
    // With no gap, start stays high so the next item follows directly.
    task automatic drive_item(cmd_t c);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        ledger.note_item(c);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= make_cmd(2'($urandom), $urandom, 8'($urandom), 8'($urandom),
                              {16'($urandom), $urandom});
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function cmd_t make_cmd(logic [1:0] op, logic [31:0] id, logic [7:0] acc,
                            logic [7:0] acd, logic [47:0] now);
        cmd_t c;
        c.op           = op;
        c.dispute_id   = id;
        c.accuser_node = acc;
        c.accused_node = acd;
        c.now_ms       = now;
        return c;
    endfunction

    // Advance the running clock; now and then jump to a fully random stamp
    // so that the upper timestamp bits toggle too.
    function logic [47:0] next_stamp();
        if ($urandom_range(0, 99) < 5)
            clock_ms = {16'($urandom), $urandom};
        else
            clock_ms = clock_ms + 48'($urandom_range(0, 5000));
        return clock_ms;
    endfunction

    // One random item. Ids mostly come from the pool so that opens, escalations
    // and resolves land on the same records; a few strays hit unknown ids.
    function cmd_t random_cmd();
        int          k;
        logic [1:0]  op;
        logic [31:0] id;
        logic [7:0]  acc;
        logic [7:0]  acd;
        k = $urandom_range(0, 99);
        if (k < 35)
            op = OP_OPEN;
        else if (k < 65)
            op = OP_ESCALATE;
        else if (k < 82)
            op = OP_RESOLVE;
        else
            op = OP_QUERY;
        if ($urandom_range(0, 99) < 90)
            id = id_pool[$urandom_range(0, id_pool.size() - 1)];
        else
            id = $urandom;
        k = $urandom_range(0, 99);
        if (op != OP_OPEN)
        begin
            // nodes are ignored here; drive noise
            acc = 8'($urandom);
            acd = 8'($urandom);
        end
        else if (k < 8)
        begin
            acc = 8'($urandom_range(0, 255));
            acd = 8'($urandom_range(NODE_COUNT, 255));
            if ($urandom_range(0, 1))
            begin
                acd = acc;
                acc = 8'($urandom_range(NODE_COUNT, 255));
            end
        end
        else if (k < 13)
        begin
            acc = 8'($urandom_range(0, NODE_COUNT - 1));
            acd = acc;
        end
        else
        begin
            acc = 8'($urandom_range(0, NODE_COUNT - 1));
            acd = 8'((acc + 8'($urandom_range(1, NODE_COUNT - 1))) % NODE_COUNT);
        end
        return make_cmd(op, id, acc, acd, next_stamp());
    endfunction

    // A random phase over a fresh pool of ids. A small pool keeps records
    // cycling through every level; a large one fills the table so that opens
    // find it full or fall back to the first resolved slot.
    task automatic run_phase(int n_items, int pool_size, bit steady);
        id_pool.delete();
        for (int i = 0; i < pool_size; i++)
            id_pool.push_back($urandom);
        steady_phase = steady;
        repeat (n_items) drive_item(random_cmd());
        steady_phase = 1'b0;
    endtask

    // Directed opening: field extremes, every operation and the rule corners.
    task automatic run_directed();
        logic [31:0] id_lo;
        logic [31:0] id_hi;
        logic [31:0] id_mid;
        id_lo  = 32'h0000_0000;
        id_hi  = 32'hFFFF_FFFF;
        id_mid = 32'h5A5A_A5A5;
        drive_item(make_cmd(OP_OPEN, id_lo, 8'd0, 8'(NODE_COUNT - 1), 48'd0));
        drive_item(make_cmd(OP_OPEN, id_hi, 8'(NODE_COUNT - 1), 8'd0, '1));
        // node ids out of range on either side
        drive_item(make_cmd(OP_OPEN, id_mid, 8'(NODE_COUNT), 8'd1, 48'd10));
        drive_item(make_cmd(OP_OPEN, id_mid, 8'd1, 8'hFF, 48'd11));
        drive_item(make_cmd(OP_OPEN, id_mid, 8'hFF, 8'hFF, 48'd12));
        // same node on both sides
        drive_item(make_cmd(OP_OPEN, id_mid, 8'd3, 8'd3, 48'd13));
        // duplicate of an active record
        drive_item(make_cmd(OP_OPEN, id_lo, 8'd2, 8'd3, 48'd14));
        drive_item(make_cmd(OP_QUERY, id_lo, 8'hAA, 8'h55, 48'd15));
        // walk one record through every level; assembly raises a broadcast
        drive_item(make_cmd(OP_ESCALATE, id_lo, 8'h00, 8'h00, 48'h1234_5678_9ABC));
        drive_item(make_cmd(OP_ESCALATE, id_lo, 8'h00, 8'h00, 48'h8000_0000_0000));
        drive_item(make_cmd(OP_ESCALATE, id_lo, 8'h00, 8'h00, '1));
        // a cut record rejects escalate, resolve and reopen but answers a query
        drive_item(make_cmd(OP_ESCALATE, id_lo, 8'h00, 8'h00, 48'd20));
        drive_item(make_cmd(OP_RESOLVE, id_lo, 8'h00, 8'h00, 48'd21));
        drive_item(make_cmd(OP_QUERY, id_lo, 8'h00, 8'h00, 48'd22));
        drive_item(make_cmd(OP_OPEN, id_lo, 8'd4, 8'd5, 48'd23));
        // resolve twice: the repeat leaves the record as it is
        drive_item(make_cmd(OP_RESOLVE, id_hi, 8'h00, 8'h00, 48'd24));
        drive_item(make_cmd(OP_RESOLVE, id_hi, 8'h00, 8'h00, 48'd25));
        drive_item(make_cmd(OP_ESCALATE, id_hi, 8'h00, 8'h00, 48'd26));
        // unknown id on every operation that looks one up
        drive_item(make_cmd(OP_QUERY, id_mid, 8'h00, 8'h00, 48'd27));
        drive_item(make_cmd(OP_ESCALATE, id_mid, 8'h00, 8'h00, 48'd28));
        drive_item(make_cmd(OP_RESOLVE, id_mid, 8'h00, 8'h00, 48'd29));
        // reopen the resolved record in its own slot, then open a new one
        drive_item(make_cmd(OP_OPEN, id_hi, 8'd7, 8'd8, 48'd30));
        drive_item(make_cmd(OP_OPEN, id_mid, 8'd4, 8'd5, 48'd31));
        drive_item(make_cmd(OP_QUERY, id_hi, 8'h00, 8'h00, 48'd32));
    endtask

    initial
    begin
        int waited;
        ledger = new();
        // hold reset, then release it at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(120, 4, 1'b0);
        run_phase(120, 24, 1'b0);
        run_phase(100, 40, 1'b1);
        run_phase(110, 12, 1'b0);
        run_phase(100, 20, 1'b0);

        @(negedge clk);
        start <= 1'b0;

        // drain: wait for every outstanding result, then go on waiting
        // to catch any stray strobe
        waited = 0;
        while (ledger.pending_results.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (12) @(posedge clk);
        if (ledger.pending_results.size() != 0)
        begin
            $error("%0d results never arrived", ledger.pending_results.size());
            ledger.mismatch_count += ledger.pending_results.size();
        end

        if (ledger.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/det_pkg.sv
rtl/det_front.sv
rtl/det_back.sv
rtl/dispute_escalation_table_unit.sv
dv/dispute_ledger_pkg.sv
dv/testbench.sv
